/* rtl/core/mfsp_pkg.sv */
package mfsp_pkg;

   // Default width of the track tick accumulator
   localparam int TIME_BITS_DEF = 32;

   // Result kinds
   localparam logic [2:0] KIND_HEADER  = 3'd0;
   localparam logic [2:0] KIND_TRACK   = 3'd1;
   localparam logic [2:0] KIND_CHANNEL = 3'd2;
   localparam logic [2:0] KIND_META    = 3'd3;
   localparam logic [2:0] KIND_SYSEX   = 3'd4;
   localparam logic [2:0] KIND_PAYLOAD = 3'd5;
   localparam logic [2:0] KIND_ERROR   = 3'd6;

   // Error codes
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_BAD_HEADER = 3'd1;
   localparam logic [2:0] ERR_FORMAT     = 3'd2;
   localparam logic [2:0] ERR_TRACK_ID   = 3'd3;
   localparam logic [2:0] ERR_CHANNEL    = 3'd4;
   localparam logic [2:0] ERR_VLQ_LONG   = 3'd5;

   // One result beat
   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] abs_time;
      logic [7:0]  status_byte;
      logic [7:0]  key;
      logic [7:0]  value;
      logic [27:0] length;
      logic [15:0] track_index;
      logic        file_format;
      logic [15:0] track_count;
      logic [15:0] division;
      logic        last;
      logic [2:0]  error_code;
   } rsp_type;

endpackage

/* rtl/core/mfsp_parse_core.sv */
module mfsp_parse_core #(
   parameter int TIME_BITS = mfsp_pkg::TIME_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  logic [7:0]       byte_in,
   output logic             res_valid,
   output mfsp_pkg::rsp_type res
);

   // Parse phases
   localparam logic [3:0] PH_HDR_ID    = 4'd0;
   localparam logic [3:0] PH_HDR_SIZE  = 4'd1;
   localparam logic [3:0] PH_HDR_FMT   = 4'd2;
   localparam logic [3:0] PH_HDR_CNT   = 4'd3;
   localparam logic [3:0] PH_HDR_DIV   = 4'd4;
   localparam logic [3:0] PH_TRK_ID    = 4'd5;
   localparam logic [3:0] PH_TRK_SIZE  = 4'd6;
   localparam logic [3:0] PH_DELTA     = 4'd7;
   localparam logic [3:0] PH_STATUS    = 4'd8;
   localparam logic [3:0] PH_DATA1     = 4'd9;
   localparam logic [3:0] PH_DATA2     = 4'd10;
   localparam logic [3:0] PH_META_TYPE = 4'd11;
   localparam logic [3:0] PH_LEN       = 4'd12;
   localparam logic [3:0] PH_PAYLOAD   = 4'd13;
   localparam logic [3:0] PH_DONE      = 4'd14;
   localparam logic [3:0] PH_HALT      = 4'd15;

   localparam logic [31:0] MTHD_ID   = 32'h4D546864;
   localparam logic [31:0] MTRK_ID   = 32'h4D54726B;
   localparam logic [31:0] MTHD_SIZE = 32'd6;
   localparam logic [7:0]  META_STAT = 8'hFF;
   localparam logic [7:0]  META_EOT  = 8'h2F;

   logic [3:0]           phase_ff, phase_in;
   logic [2:0]           byte_counter_ff, byte_counter_in;
   logic [7:0]           running_status_ff, running_status_in;
   logic [TIME_BITS-1:0] tick_time_ff, tick_time_in;
   logic [27:0]          vlq_accum_ff, vlq_accum_in;
   logic [27:0]          payload_left_ff, payload_left_in;
   logic [15:0]          tracks_left_ff, tracks_left_in;
   logic [15:0]          track_number_ff, track_number_in;
   logic [31:0]          header_shift_ff, header_shift_in;
   logic [7:0]           held_data_ff, held_data_in;
   logic [7:0]           held_status_ff, held_status_in;
   logic                 file_format_ff, file_format_in;
   logic                 end_pending_ff, end_pending_in;

   // Helpers shared by several phases
   logic [31:0]          shift_next;
   logic [2:0]           count_next;
   logic [27:0]          vlq_next;
   logic [15:0]          tracks_dec;
   logic [3:0]           finish_phase;
   logic                 chan_pair;
   logic                 chan_single;
   logic                 is_meta;
   logic                 lenb_eot;

   assign shift_next   = {header_shift_ff[23:0], byte_in};
   assign count_next   = byte_counter_ff + 3'd1;
   assign vlq_next     = {vlq_accum_ff[20:0], byte_in[6:0]};
   assign tracks_dec   = tracks_left_ff - 16'd1;
   assign finish_phase = (tracks_dec == 16'd0) ? PH_DONE : PH_TRK_ID;
   assign is_meta      = (held_status_ff == META_STAT);
   assign lenb_eot     = is_meta && (held_data_ff == META_EOT);

   // Classify the running status command nibble
   always_comb begin
      chan_pair   = 1'b0;
      chan_single = 1'b0;
      case (running_status_ff[7:4]) inside
         4'h8, 4'h9, 4'hA, 4'hB, 4'hE: chan_pair = 1'b1;
         4'hC, 4'hD:                   chan_single = 1'b1;
         default:                      ;
      endcase
   end

   // Advance the parser by one byte
   always_comb begin
      phase_in          = phase_ff;
      byte_counter_in   = byte_counter_ff;
      running_status_in = running_status_ff;
      tick_time_in      = tick_time_ff;
      vlq_accum_in      = vlq_accum_ff;
      payload_left_in   = payload_left_ff;
      tracks_left_in    = tracks_left_ff;
      track_number_in   = track_number_ff;
      header_shift_in   = header_shift_ff;
      held_data_in      = held_data_ff;
      held_status_in    = held_status_ff;
      file_format_in    = file_format_ff;
      end_pending_in    = end_pending_ff;
      res_valid         = 1'b0;
      res               = '0;
      res.abs_time      = 32'(tick_time_ff);
      res.track_index   = track_number_ff;

      if (step_en) begin
         unique case (phase_ff)
            PH_HDR_ID, PH_HDR_SIZE, PH_TRK_ID: begin
               header_shift_in = shift_next;
               if (count_next >= 3'd4) begin
                  byte_counter_in = 3'd0;
                  if (phase_ff == PH_HDR_ID && shift_next != MTHD_ID) begin
                     phase_in       = PH_HALT;
                     res_valid      = 1'b1;
                     res.kind       = mfsp_pkg::KIND_ERROR;
                     res.error_code = mfsp_pkg::ERR_BAD_HEADER;
                  end else if (phase_ff == PH_HDR_SIZE && shift_next != MTHD_SIZE) begin
                     phase_in       = PH_HALT;
                     res_valid      = 1'b1;
                     res.kind       = mfsp_pkg::KIND_ERROR;
                     res.error_code = mfsp_pkg::ERR_BAD_HEADER;
                  end else if (phase_ff == PH_TRK_ID && shift_next != MTRK_ID) begin
                     phase_in       = PH_HALT;
                     res_valid      = 1'b1;
                     res.kind       = mfsp_pkg::KIND_ERROR;
                     res.error_code = mfsp_pkg::ERR_TRACK_ID;
                  end else if (phase_ff == PH_HDR_ID) begin
                     phase_in = PH_HDR_SIZE;
                  end else if (phase_ff == PH_HDR_SIZE) begin
                     phase_in = PH_HDR_FMT;
                  end else begin
                     phase_in = PH_TRK_SIZE;
                  end
               end else begin
                  byte_counter_in = count_next;
               end
            end
            PH_HDR_FMT: begin
               header_shift_in = shift_next;
               if (count_next >= 3'd2) begin
                  byte_counter_in = 3'd0;
                  if (shift_next[15:0] > 16'd1) begin
                     phase_in       = PH_HALT;
                     res_valid      = 1'b1;
                     res.kind       = mfsp_pkg::KIND_ERROR;
                     res.error_code = mfsp_pkg::ERR_FORMAT;
                  end else begin
                     file_format_in = shift_next[0];
                     phase_in       = PH_HDR_CNT;
                  end
               end else begin
                  byte_counter_in = count_next;
               end
            end
            PH_HDR_CNT: begin
               header_shift_in = shift_next;
               if (count_next >= 3'd2) begin
                  byte_counter_in = 3'd0;
                  tracks_left_in  = shift_next[15:0];
                  phase_in        = PH_HDR_DIV;
               end else begin
                  byte_counter_in = count_next;
               end
            end
            PH_HDR_DIV: begin
               header_shift_in = shift_next;
               if (count_next >= 3'd2) begin
                  byte_counter_in = 3'd0;
                  phase_in        = (tracks_left_ff == 16'd0) ? PH_DONE : PH_TRK_ID;
                  res_valid       = 1'b1;
                  res.kind        = mfsp_pkg::KIND_HEADER;
                  res.abs_time    = 32'd0;
                  res.file_format = file_format_ff;
                  res.track_count = tracks_left_ff;
                  res.division    = shift_next[15:0];
               end else begin
                  byte_counter_in = count_next;
               end
            end
            PH_TRK_SIZE: begin
               header_shift_in = shift_next;
               if (count_next >= 3'd4) begin
                  byte_counter_in   = 3'd0;
                  tick_time_in      = '0;
                  running_status_in = 8'd0;
                  end_pending_in    = 1'b0;
                  vlq_accum_in      = 28'd0;
                  phase_in          = PH_DELTA;
                  res_valid         = 1'b1;
                  res.kind          = mfsp_pkg::KIND_TRACK;
                  res.abs_time      = 32'd0;
               end else begin
                  byte_counter_in = count_next;
               end
            end
            PH_DELTA: begin
               vlq_accum_in = vlq_next;
               if (!byte_in[7]) begin
                  byte_counter_in = 3'd0;
                  tick_time_in    = tick_time_ff + TIME_BITS'(vlq_next);
                  vlq_accum_in    = 28'd0;
                  phase_in        = PH_STATUS;
               end else begin
                  byte_counter_in = count_next;
                  if (count_next >= 3'd4) begin
                     phase_in       = PH_HALT;
                     res_valid      = 1'b1;
                     res.kind       = mfsp_pkg::KIND_ERROR;
                     res.error_code = mfsp_pkg::ERR_VLQ_LONG;
                  end
               end
            end
            PH_STATUS, PH_DATA1: begin
               if (phase_ff == PH_STATUS && byte_in >= 8'hF0) begin
                  // Meta and system events drop running status
                  running_status_in = 8'd0;
                  held_status_in    = byte_in;
                  held_data_in      = 8'd0;
                  vlq_accum_in      = 28'd0;
                  phase_in          = (byte_in == META_STAT) ? PH_META_TYPE : PH_LEN;
               end else if (phase_ff == PH_STATUS && byte_in[7]) begin
                  running_status_in = byte_in;
                  phase_in          = PH_DATA1;
               end else if (chan_pair) begin
                  held_data_in = byte_in;
                  phase_in     = PH_DATA2;
               end else if (chan_single) begin
                  phase_in        = PH_DELTA;
                  res_valid       = 1'b1;
                  res.kind        = mfsp_pkg::KIND_CHANNEL;
                  res.status_byte = running_status_ff;
                  res.value       = byte_in;
               end else begin
                  phase_in       = PH_HALT;
                  res_valid      = 1'b1;
                  res.kind       = mfsp_pkg::KIND_ERROR;
                  res.error_code = mfsp_pkg::ERR_CHANNEL;
               end
            end
            PH_DATA2: begin
               phase_in        = PH_DELTA;
               res_valid       = 1'b1;
               res.kind        = mfsp_pkg::KIND_CHANNEL;
               res.status_byte = running_status_ff;
               res.key         = held_data_ff;
               res.value       = byte_in;
            end
            PH_META_TYPE: begin
               held_data_in = byte_in;
               vlq_accum_in = 28'd0;
               phase_in     = PH_LEN;
            end
            PH_LEN: begin
               vlq_accum_in = vlq_next;
               if (!byte_in[7]) begin
                  byte_counter_in = 3'd0;
                  vlq_accum_in    = 28'd0;
                  payload_left_in = vlq_next;
                  end_pending_in  = lenb_eot;
                  res_valid       = 1'b1;
                  res.kind        = is_meta ? mfsp_pkg::KIND_META : mfsp_pkg::KIND_SYSEX;
                  res.status_byte = held_status_ff;
                  res.key         = is_meta ? held_data_ff : 8'd0;
                  res.length      = vlq_next;
                  res.last        = (vlq_next == 28'd0);
                  if (vlq_next != 28'd0) begin
                     phase_in = PH_PAYLOAD;
                  end else if (lenb_eot) begin
                     // Zero-length end of track closes the track here
                     end_pending_in  = 1'b0;
                     track_number_in = track_number_ff + 16'd1;
                     tracks_left_in  = tracks_dec;
                     phase_in        = finish_phase;
                  end else begin
                     phase_in = PH_DELTA;
                  end
               end else begin
                  byte_counter_in = count_next;
                  if (count_next >= 3'd4) begin
                     phase_in       = PH_HALT;
                     res_valid      = 1'b1;
                     res.kind       = mfsp_pkg::KIND_ERROR;
                     res.error_code = mfsp_pkg::ERR_VLQ_LONG;
                  end
               end
            end
            PH_PAYLOAD: begin
               res_valid       = 1'b1;
               res.kind        = mfsp_pkg::KIND_PAYLOAD;
               res.status_byte = held_status_ff;
               res.key         = is_meta ? held_data_ff : 8'd0;
               res.value       = byte_in;
               res.last        = (payload_left_ff <= 28'd1);
               if (payload_left_ff <= 28'd1) begin
                  payload_left_in = 28'd0;
                  if (end_pending_ff) begin
                     end_pending_in  = 1'b0;
                     track_number_in = track_number_ff + 16'd1;
                     tracks_left_in  = tracks_dec;
                     phase_in        = finish_phase;
                  end else begin
                     phase_in = PH_DELTA;
                  end
               end else begin
                  payload_left_in = payload_left_ff - 28'd1;
               end
            end
            default: ;
         endcase
      end
   end

   // Hold parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_HDR_ID;
         byte_counter_ff   <= 3'd0;
         running_status_ff <= 8'd0;
         tick_time_ff      <= '0;
         vlq_accum_ff      <= 28'd0;
         payload_left_ff   <= 28'd0;
         tracks_left_ff    <= 16'd0;
         track_number_ff   <= 16'd0;
         header_shift_ff   <= 32'd0;
         held_data_ff      <= 8'd0;
         held_status_ff    <= 8'd0;
         file_format_ff    <= 1'b0;
         end_pending_ff    <= 1'b0;
      end else begin
         phase_ff          <= phase_in;
         byte_counter_ff   <= byte_counter_in;
         running_status_ff <= running_status_in;
         tick_time_ff      <= tick_time_in;
         vlq_accum_ff      <= vlq_accum_in;
         payload_left_ff   <= payload_left_in;
         tracks_left_ff    <= tracks_left_in;
         track_number_ff   <= track_number_in;
         header_shift_ff   <= header_shift_in;
         held_data_ff      <= held_data_in;
         held_status_ff    <= held_status_in;
         file_format_ff    <= file_format_in;
         end_pending_ff    <= end_pending_in;
      end
   end

   // An error result always halts the parser
   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      step_en && res_valid && res.kind == mfsp_pkg::KIND_ERROR |=> phase_ff == PH_HALT)
      else $error("error result without halt");

   // Halt is sticky until reset
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HALT |=> phase_ff == PH_HALT)
      else $error("parser left halt");

   // Done and halted phases produce nothing
   a_quiet_when_stopped: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DONE || phase_ff == PH_HALT |-> !res_valid)
      else $error("result from stopped parser");

endmodule

/* rtl/core/midi_file_stream_parser.sv */
// Channel | Dir | Handshake          | Beat contents
// req     | in  | req_valid/ready    | req_byte_in: one file byte
// rsp     | out | rsp_valid/ready    | rsp_kind ... rsp_error_code: one parse result
//
// One byte per clock sustained while rsp beats drain; a taken byte waits in the
// input register, the parse step loads the result register, and rsp_valid rises.
// Synchronous active-high reset puts the parser back at the file header.
// A held rsp beat stalls the parse step; req_ready drops in the same cycle
// once the input register is full and the result register cannot drain.
module midi_file_stream_parser #(
   parameter int TIME_BITS = mfsp_pkg::TIME_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_abs_time,
   output logic [7:0]  rsp_status_byte,
   output logic [7:0]  rsp_key,
   output logic [7:0]  rsp_value,
   output logic [27:0] rsp_length,
   output logic [15:0] rsp_track_index,
   output logic        rsp_file_format,
   output logic [15:0] rsp_track_count,
   output logic [15:0] rsp_division,
   output logic        rsp_last,
   output logic [2:0]  rsp_error_code
);

   logic              in_valid_ff, in_valid_in;
   logic [7:0]        byte_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   mfsp_pkg::rsp_type rsp_ff;
   logic              out_free;
   logic              advance;
   logic              res_valid;
   mfsp_pkg::rsp_type res;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   mfsp_parse_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .byte_in   (byte_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   // Input register occupancy
   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // Result register occupancy: refill on a step, drain when taken
   always_comb begin
      if (out_free) begin
         rsp_valid_in = advance && res_valid;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the byte beat and the result beat
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_byte_in;
      end
      if (advance && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_ff.kind;
   assign rsp_abs_time    = rsp_ff.abs_time;
   assign rsp_status_byte = rsp_ff.status_byte;
   assign rsp_key         = rsp_ff.key;
   assign rsp_value       = rsp_ff.value;
   assign rsp_length      = rsp_ff.length;
   assign rsp_track_index = rsp_ff.track_index;
   assign rsp_file_format = rsp_ff.file_format;
   assign rsp_track_count = rsp_ff.track_count;
   assign rsp_division    = rsp_ff.division;
   assign rsp_last        = rsp_ff.last;
   assign rsp_error_code  = rsp_ff.error_code;

   // A stalled step keeps its byte in the input register
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(byte_ff))
      else $error("input byte lost during stall");

   // A stalled result beat holds its contents
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("result beat changed during stall");

   // An empty input register always takes a beat
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("input stalled while empty");

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;

   // File framing
   localparam logic [31:0] MTHD_ID        = 32'h4D54_6864;
   localparam logic [31:0] MTRK_ID        = 32'h4D54_726B;
   localparam logic [31:0] HDR_LEN        = 32'd6;
   localparam logic [15:0] TRACKS_DECLARED = 16'd32;

   // Status bytes and meta types
   localparam logic [7:0] META_STATUS    = 8'hFF;
   localparam logic [7:0] SYSEX_STATUS   = 8'hF0;
   localparam logic [7:0] SYSEX_ESCAPE   = 8'hF7;
   localparam logic [7:0] SYS_LOW        = 8'hF1;
   localparam logic [7:0] SYS_HIGH       = 8'hFE;
   localparam logic [7:0] DATA_LIMIT     = 8'h80;
   localparam logic [7:0] META_END_TRACK = 8'h2F;
   localparam logic [7:0] META_TEMPO     = 8'h51;
   localparam logic [7:0] META_SEQUENCER = 8'h7F;

   // Channel commands (upper nibble of status)
   localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
   localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
   localparam logic [3:0] CMD_POLY_AT  = 4'hA;
   localparam logic [3:0] CMD_CONTROL  = 4'hB;
   localparam logic [3:0] CMD_PROGRAM  = 4'hC;
   localparam logic [3:0] CMD_CHAN_AT  = 4'hD;
   localparam logic [3:0] CMD_PITCH    = 4'hE;

   // Ways to close the file
   localparam int END_ALL_TRACKS   = 0;
   localparam int END_BAD_TRACK_ID = 1;
   localparam int END_LONG_DELTA   = 2;
   localparam int END_LONG_LENGTH  = 3;
   localparam int END_BAD_CHANNEL  = 4;

   localparam int RANDOM_BYTES = 300;
   localparam int CYCLE_LIMIT  = 200000;

   typedef enum logic [3:0] {
      ST_HDR_ID, ST_HDR_SIZE, ST_HDR_FMT, ST_HDR_CNT, ST_HDR_DIV, ST_TRK_ID, ST_TRK_SIZE,
      ST_DELTA, ST_STATUS, ST_DATA1, ST_DATA2, ST_META_TYPE, ST_LEN, ST_PAYLOAD,
      ST_DONE, ST_HALT
   } parse_state_type;

   typedef enum logic [1:0] {VLQ_MORE, VLQ_DONE, VLQ_LONG} vlq_step_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_byte_in = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_kind;
   logic [31:0] rsp_abs_time;
   logic [7:0]  rsp_status_byte;
   logic [7:0]  rsp_key;
   logic [7:0]  rsp_value;
   logic [27:0] rsp_length;
   logic [15:0] rsp_track_index;
   logic        rsp_file_format;
   logic [15:0] rsp_track_count;
   logic [15:0] rsp_division;
   logic        rsp_last;
   logic [2:0]  rsp_error_code;

   // Parser shadow state
   parse_state_type parse_st = ST_HDR_ID;
   logic [2:0]   cnt = '0;
   logic [7:0]   run_status = '0;
   logic [31:0]  ticks = '0;
   logic [27:0]  vlq = '0;
   logic [27:0]  left = '0;
   logic [15:0]  trk_left = '0;
   logic [15:0]  trk_num = '0;
   logic [31:0]  hdr_shift = '0;
   logic [7:0]   hold_data = '0;
   logic [7:0]   hold_status = '0;
   logic         fmt_bit = 1'b0;
   logic [15:0]  div_word = '0;
   logic         end_flag = 1'b0;

   mfsp_pkg::rsp_type expected_results[$];
   int          mismatches = 0;
   int          bytes_sent = 0;
   int          tracks_sent = 0;
   int unsigned cycle_count = 0;
   bit          gaps_on = 1'b1;
   logic [7:0]  chan_status = '0;

   midi_file_stream_parser i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_byte_in     (req_byte_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_abs_time    (rsp_abs_time),
      .rsp_status_byte (rsp_status_byte),
      .rsp_key         (rsp_key),
      .rsp_value       (rsp_value),
      .rsp_length      (rsp_length),
      .rsp_track_index (rsp_track_index),
      .rsp_file_format (rsp_file_format),
      .rsp_track_count (rsp_track_count),
      .rsp_division    (rsp_division),
      .rsp_last        (rsp_last),
      .rsp_error_code  (rsp_error_code)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Parser prediction
   // ------------------------------------------------------------------

   function automatic mfsp_pkg::rsp_type make_result(logic [2:0] kind, logic [7:0] status,
                                                     logic [7:0] key_b, logic [7:0] val_b,
                                                     logic [27:0] len, logic last_b);
      mfsp_pkg::rsp_type r;
      r = '0;
      r.kind = kind;
      r.abs_time = (kind == mfsp_pkg::KIND_HEADER) ? 32'd0 : ticks;
      r.status_byte = status;
      r.key = key_b;
      r.value = val_b;
      r.length = len;
      r.track_index = trk_num;
      r.last = last_b;
      return r;
   endfunction

   function automatic void halt_with(logic [2:0] code);
      mfsp_pkg::rsp_type r;
      parse_st = ST_HALT;
      r = make_result(mfsp_pkg::KIND_ERROR, '0, '0, '0, '0, 1'b0);
      r.error_code = code;
      expected_results.push_back(r);
   endfunction

   // Shift a framing byte in; true once n bytes are gathered
   function automatic bit shift_in(logic [7:0] b, logic [2:0] n);
      hdr_shift = {hdr_shift[23:0], b};
      cnt = cnt + 3'd1;
      if (cnt >= n) begin
         cnt = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic vlq_step_type take_vlq(logic [7:0] b);
      vlq = {vlq[20:0], b[6:0]};
      cnt = cnt + 3'd1;
      if (!b[7]) begin
         cnt = '0;
         return VLQ_DONE;
      end
      if (cnt >= 3'd4) return VLQ_LONG;
      return VLQ_MORE;
   endfunction

   function automatic void close_event();
      if (end_flag) begin
         end_flag = 1'b0;
         trk_num = trk_num + 16'd1;
         trk_left = trk_left - 16'd1;
         parse_st = (trk_left == 16'd0) ? ST_DONE : ST_TRK_ID;
      end else begin
         parse_st = ST_DELTA;
      end
   endfunction

   // First data byte under the current running status
   function automatic void channel_first(logic [7:0] b);
      case (run_status[7:4])
         CMD_NOTE_OFF, CMD_NOTE_ON, CMD_POLY_AT, CMD_CONTROL, CMD_PITCH: begin
            hold_data = b;
            parse_st = ST_DATA2;
         end
         CMD_PROGRAM, CMD_CHAN_AT: begin
            parse_st = ST_DELTA;
            expected_results.push_back(make_result(mfsp_pkg::KIND_CHANNEL, run_status, '0, b,
                                                   '0, 1'b0));
         end
         default: halt_with(mfsp_pkg::ERR_CHANNEL);
      endcase
   endfunction

   function automatic void parse_file_byte(logic [7:0] b);
      mfsp_pkg::rsp_type r;
      logic [27:0]  len;
      logic         is_meta;
      logic         last_b;
      vlq_step_type vs;
      case (parse_st)
         ST_HDR_ID: if (shift_in(b, 3'd4)) begin
            if (hdr_shift != MTHD_ID) halt_with(mfsp_pkg::ERR_BAD_HEADER);
            else parse_st = ST_HDR_SIZE;
         end
         ST_HDR_SIZE: if (shift_in(b, 3'd4)) begin
            if (hdr_shift != HDR_LEN) halt_with(mfsp_pkg::ERR_BAD_HEADER);
            else parse_st = ST_HDR_FMT;
         end
         ST_HDR_FMT: if (shift_in(b, 3'd2)) begin
            if (hdr_shift[15:0] > 16'd1) begin
               halt_with(mfsp_pkg::ERR_FORMAT);
            end else begin
               fmt_bit = hdr_shift[0];
               parse_st = ST_HDR_CNT;
            end
         end
         ST_HDR_CNT: if (shift_in(b, 3'd2)) begin
            trk_left = hdr_shift[15:0];
            parse_st = ST_HDR_DIV;
         end
         ST_HDR_DIV: if (shift_in(b, 3'd2)) begin
            div_word = hdr_shift[15:0];
            parse_st = (trk_left == 16'd0) ? ST_DONE : ST_TRK_ID;
            r = make_result(mfsp_pkg::KIND_HEADER, '0, '0, '0, '0, 1'b0);
            r.file_format = fmt_bit;
            r.track_count = trk_left;
            r.division = div_word;
            expected_results.push_back(r);
         end
         ST_TRK_ID: if (shift_in(b, 3'd4)) begin
            if (hdr_shift != MTRK_ID) halt_with(mfsp_pkg::ERR_TRACK_ID);
            else parse_st = ST_TRK_SIZE;
         end
         ST_TRK_SIZE: if (shift_in(b, 3'd4)) begin
            ticks = '0;
            run_status = '0;
            end_flag = 1'b0;
            vlq = '0;
            parse_st = ST_DELTA;
            expected_results.push_back(make_result(mfsp_pkg::KIND_TRACK, '0, '0, '0, '0,
                                                   1'b0));
         end
         ST_DELTA: begin
            vs = take_vlq(b);
            if (vs == VLQ_LONG) begin
               halt_with(mfsp_pkg::ERR_VLQ_LONG);
            end else if (vs == VLQ_DONE) begin
               ticks = ticks + {4'd0, vlq};
               vlq = '0;
               parse_st = ST_STATUS;
            end
         end
         ST_STATUS: begin
            if (b < DATA_LIMIT) begin
               channel_first(b);
            end else if (b < SYSEX_STATUS) begin
               run_status = b;
               parse_st = ST_DATA1;
            end else begin
               run_status = '0;
               hold_status = b;
               hold_data = '0;
               vlq = '0;
               parse_st = (b == META_STATUS) ? ST_META_TYPE : ST_LEN;
            end
         end
         ST_DATA1: channel_first(b);
         ST_DATA2: begin
            parse_st = ST_DELTA;
            expected_results.push_back(make_result(mfsp_pkg::KIND_CHANNEL, run_status,
                                                   hold_data, b, '0, 1'b0));
         end
         ST_META_TYPE: begin
            hold_data = b;
            vlq = '0;
            parse_st = ST_LEN;
         end
         ST_LEN: begin
            vs = take_vlq(b);
            if (vs == VLQ_LONG) begin
               halt_with(mfsp_pkg::ERR_VLQ_LONG);
            end else if (vs == VLQ_DONE) begin
               is_meta = (hold_status == META_STATUS);
               len = vlq;
               vlq = '0;
               left = len;
               end_flag = is_meta && (hold_data == META_END_TRACK);
               expected_results.push_back(make_result(is_meta ? mfsp_pkg::KIND_META :
                                                                mfsp_pkg::KIND_SYSEX,
                                                      hold_status, is_meta ? hold_data : 8'h00,
                                                      '0, len, len == 28'd0));
               if (len == 28'd0) close_event();
               else parse_st = ST_PAYLOAD;
            end
         end
         ST_PAYLOAD: begin
            is_meta = (hold_status == META_STATUS);
            last_b = (left <= 28'd1);
            expected_results.push_back(make_result(mfsp_pkg::KIND_PAYLOAD, hold_status,
                                                   is_meta ? hold_data : 8'h00, b, '0, last_b));
            left = last_b ? 28'd0 : left - 28'd1;
            if (last_b) close_event();
         end
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   task automatic report_error(string msg);
      mismatches++;
      $display("ERROR at %0t: %s", $time, msg);
   endtask

   task automatic check_field(string name, logic [31:0] got_v, logic [31:0] want_v);
      if (got_v !== want_v)
         report_error($sformatf("%s got %0h, expected %0h", name, got_v, want_v));
   endtask

   task automatic compare_results(mfsp_pkg::rsp_type got, mfsp_pkg::rsp_type want);
      check_field("kind", 32'(got.kind), 32'(want.kind));
      check_field("abs_time", got.abs_time, want.abs_time);
      check_field("status_byte", 32'(got.status_byte), 32'(want.status_byte));
      check_field("key", 32'(got.key), 32'(want.key));
      check_field("value", 32'(got.value), 32'(want.value));
      check_field("length", 32'(got.length), 32'(want.length));
      check_field("track_index", 32'(got.track_index), 32'(want.track_index));
      check_field("file_format", 32'(got.file_format), 32'(want.file_format));
      check_field("track_count", 32'(got.track_count), 32'(want.track_count));
      check_field("division", 32'(got.division), 32'(want.division));
      check_field("last", 32'(got.last), 32'(want.last));
      check_field("error_code", 32'(got.error_code), 32'(want.error_code));
   endtask

   // Check result beats against the oldest expectation, then predict taken bytes
   always @(posedge clock) begin : result_monitor
      mfsp_pkg::rsp_type got;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_kind, rsp_abs_time, rsp_status_byte, rsp_key, rsp_value, rsp_length,
                   rsp_track_index, rsp_file_format, rsp_track_count, rsp_division,
                   rsp_last, rsp_error_code};
            if (expected_results.size() == 0)
               report_error($sformatf("unexpected result beat, kind %0d", rsp_kind));
            else
               compare_results(got, expected_results.pop_front());
         end
         if (req_valid && req_ready) parse_file_byte(req_byte_in);
      end
   end

   // Stall the result side at random
   always @(posedge clock) begin
      rsp_ready <= gaps_on ? ($urandom_range(99) >= 32) : 1'b1;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("midi_file_stream_parser test failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   // Offer one file byte; return at the edge that takes it
   task automatic send_byte(logic [7:0] b);
      while (gaps_on && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte_in <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_word(logic [31:0] w, int n);
      for (int i = n - 1; i >= 0; i--) send_byte(w[8*i +: 8]);
   endtask

   // Variable-length quantity in exactly n bytes, leading zero groups allowed
   task automatic send_vlq(logic [27:0] v, int n);
      logic [27:0] part;
      for (int i = n - 1; i >= 0; i--) begin
         part = v >> (7 * i);
         send_byte({(i > 0) ? 1'b1 : 1'b0, part[6:0]});
      end
   endtask

   task automatic send_random_delta(bit big);
      int          sel;
      int          n;
      logic [27:0] v;
      v = 28'($urandom);
      if (big) begin
         n = 4;
         v[27:26] = 2'b11;
      end else begin
         sel = $urandom_range(99);
         n = (sel < 60) ? 1 : (sel < 80) ? 2 : (sel < 92) ? 3 : 4;
         v = v & 28'((32'd1 << (7 * n)) - 1);
      end
      send_vlq(v, n);
   endtask

   task automatic send_channel(logic [7:0] status, logic [7:0] d1, logic [7:0] d2,
                               bit with_status);
      if (with_status) send_byte(status);
      send_byte(d1);
      if (status[7:4] != CMD_PROGRAM && status[7:4] != CMD_CHAN_AT) send_byte(d2);
      chan_status = status;
   endtask

   // Meta or system event: status, type for meta, length, payload
   task automatic send_blob(logic [7:0] status, logic [7:0] meta_type, int len, int len_bytes);
      send_byte(status);
      if (status == META_STATUS) send_byte(meta_type);
      send_vlq(28'(len), len_bytes);
      repeat (len) send_byte(8'($urandom_range(0, 255)));
      chan_status = '0;
   endtask

   task automatic send_random_event(bit big);
      int         sel;
      int         len;
      int         len_bytes;
      logic [3:0] cmd_n;
      logic [3:0] chan_n;
      logic [7:0] status;
      logic [7:0] mtype;
      send_random_delta(big);
      sel = $urandom_range(99);
      if (sel < 60) begin
         if (sel >= 35 && chan_status != 8'h00) begin
            send_channel(chan_status, 8'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                         1'b0);
         end else begin
            cmd_n = 4'($urandom_range(CMD_NOTE_OFF, CMD_PITCH));
            chan_n = 4'($urandom_range(0, 15));
            send_channel({cmd_n, chan_n}, 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 1'b1);
         end
      end else begin
         sel = $urandom_range(99);
         len = (sel < 70) ? $urandom_range(0, 6) :
               (sel < 95) ? $urandom_range(7, 40) : $urandom_range(128, 200);
         len_bytes = ((len > 127) ? 2 : 1) + (($urandom_range(3) == 0) ? 1 : 0);
         sel = $urandom_range(99);
         if (sel < 55) begin
            mtype = 8'($urandom_range(0, 255));
            if (mtype == META_END_TRACK) mtype = META_TEMPO;
            send_blob(META_STATUS, mtype, len, len_bytes);
         end else begin
            status = (sel < 75) ? SYSEX_STATUS :
                     (sel < 85) ? SYSEX_ESCAPE : 8'($urandom_range(SYS_LOW, SYS_HIGH));
            send_blob(status, '0, len, len_bytes);
         end
      end
   endtask

   task automatic send_track_start();
      send_word(MTRK_ID, 4);
      send_word($urandom, 4);
      chan_status = '0;
      tracks_sent++;
   endtask

   task automatic send_track_end();
      send_random_delta(1'b0);
      send_blob(META_STATUS, META_END_TRACK,
                ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0, 1);
   endtask

   // Big tracks use long deltas throughout so the tick time wraps
   task automatic send_random_track(bit big);
      int n;
      n = big ? $urandom_range(20, 24) : $urandom_range(1, 10);
      send_track_start();
      repeat (n) send_random_event(big);
      send_track_end();
   endtask

   // Hold the sender until every predicted result has come out
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   task automatic test_header();
      send_word(MTHD_ID, 4);
      send_word(HDR_LEN, 4);
      send_word($urandom_range(0, 1), 2);
      send_word(32'(TRACKS_DECLARED), 2);
      send_word($urandom_range(0, 65535), 2);
   endtask

   // Every channel command, running status, meta and system forms in one track
   task automatic test_event_kinds();
      send_track_start();
      send_vlq(28'd0, 1);
      send_channel({CMD_NOTE_OFF, 4'h0}, 8'h00, 8'h00, 1'b1);
      send_vlq(28'h7F, 1);
      send_channel({CMD_NOTE_ON, 4'hF}, 8'h7F, 8'hFF, 1'b1);
      send_vlq(28'd0, 2);
      send_channel({CMD_NOTE_ON, 4'hF}, 8'h00, 8'h80, 1'b0);
      send_vlq(28'hFFF_FFFF, 4);
      send_channel({CMD_POLY_AT, 4'h5}, 8'hFF, 8'h00, 1'b1);
      send_vlq(28'd1, 1);
      send_channel({CMD_CONTROL, 4'h0}, 8'h40, 8'h7F, 1'b1);
      send_vlq(28'd0, 1);
      send_channel({CMD_PROGRAM, 4'h3}, 8'hFF, 8'h00, 1'b1);
      send_vlq(28'd0, 1);
      send_channel({CMD_PROGRAM, 4'h3}, 8'h00, 8'h00, 1'b0);
      send_vlq(28'd0, 1);
      send_channel({CMD_CHAN_AT, 4'h1}, 8'h80, 8'h00, 1'b1);
      send_vlq(28'd0, 1);
      send_channel({CMD_PITCH, 4'h2}, 8'h00, 8'h40, 1'b1);
      send_vlq(28'd0, 1);
      send_blob(META_STATUS, META_TEMPO, 3, 1);
      send_vlq(28'd0, 1);
      send_blob(SYSEX_STATUS, '0, 2, 1);
      send_vlq(28'd0, 1);
      send_blob(SYSEX_ESCAPE, '0, 0, 1);
      send_vlq(28'd0, 1);
      send_blob(SYS_LOW, '0, 1, 1);
      send_vlq(28'd0, 1);
      send_blob(SYS_HIGH, '0, 0, 2);
      send_vlq(28'd0, 1);
      send_blob(META_STATUS, META_SEQUENCER, 0, 1);
      send_vlq(28'd0, 1);
      send_blob(META_STATUS, META_END_TRACK, 1, 1);
   endtask

   task automatic test_random_tracks();
      int  start;
      bit  drained;
      start = bytes_sent;
      drained = 1'b0;
      while (bytes_sent - start < RANDOM_BYTES && tracks_sent < TRACKS_DECLARED - 6) begin
         send_random_track($urandom_range(0, 5) == 0);
         if (!drained && bytes_sent - start > RANDOM_BYTES / 2) begin
            wait_for_results();
            drained = 1'b1;
         end
      end
   endtask

   task automatic test_steady_flow();
      gaps_on = 1'b0;
      repeat (3) send_random_track(1'b0);
      gaps_on = 1'b1;
   endtask

   // Close the file one way per run; the parser then ignores all further bytes
   task automatic test_file_ending();
      case ($urandom_range(END_ALL_TRACKS, END_BAD_CHANNEL))
         END_ALL_TRACKS: begin
            while (tracks_sent < TRACKS_DECLARED) begin
               send_track_start();
               send_track_end();
            end
         end
         END_BAD_TRACK_ID: send_word(MTRK_ID ^ (32'd1 << $urandom_range(0, 31)), 4);
         END_LONG_DELTA: begin
            send_track_start();
            repeat (4) send_byte(8'($urandom_range(128, 255)));
         end
         END_LONG_LENGTH: begin
            send_track_start();
            send_vlq(28'd0, 1);
            send_byte(8'($urandom_range(SYSEX_STATUS, SYS_HIGH)));
            repeat (4) send_byte(8'($urandom_range(128, 255)));
         end
         default: begin
            send_track_start();
            send_vlq(28'd0, 1);
            if ($urandom_range(1)) begin
               send_blob(SYSEX_STATUS, '0, 0, 1);
               send_vlq(28'd0, 1);
            end
            send_byte(8'($urandom_range(0, 127)));
         end
      endcase
      repeat (16) send_byte(8'($urandom_range(0, 255)));
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_header();
      test_event_kinds();
      test_random_tracks();
      test_steady_flow();
      test_file_ending();
      wait_for_results();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("midi_file_stream_parser test passed");
      end else begin
         $display("midi_file_stream_parser test failed");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/mfsp_pkg.sv
rtl/core/mfsp_parse_core.sv
rtl/core/midi_file_stream_parser.sv
sim/tb.sv
